// ===== hdl/ccce_pkg.sv =====
// ============================================================================
// ccce_pkg
// Shared types and constants of the capture/compare channel engine.
// ============================================================================
`default_nettype none

package ccce_pkg;

   localparam int CHANNELS_DEF = 4;
   localparam int CHAN_W       = 2;
   localparam int MODE_W       = 3;
   localparam int ARG_W        = 16;
   localparam int VAL_W        = 16;
   localparam int OVF_W        = 8;
   localparam int STAMP_W      = OVF_W + VAL_W;
   localparam int DIFF_W       = 32;
   localparam int SHIFT_W      = 5;

   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARG_BASE  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REG_END   = 4'd8;

   localparam logic [VAL_W-1:0] DUR_SAT = 16'hffff;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF      = 3'd0,
      MODE_CAP_CONT = 3'd1,
      MODE_CAP_ONCE = 3'd2,
      MODE_PWM      = 3'd3,
      MODE_TIMER    = 3'd4,
      MODE_PULSE    = 3'd5
   } mode_type;

   typedef struct packed {
      logic               overflow;
      logic               event_valid;
      logic [CHAN_W-1:0]  event_channel;
      logic [VAL_W-1:0]   capture_value;
   } item_type;

   typedef struct packed {
      logic               report_valid;
      logic [CHAN_W-1:0]  report_channel;
      logic [VAL_W-1:0]   duration;
      logic               compare_valid;
      logic [VAL_W-1:0]   compare_value;
      logic               disarm;
   } result_type;

   typedef struct packed {
      logic               valid;
      logic [CHAN_W-1:0]  channel;
      logic [MODE_W-1:0]  mode;
      logic [ARG_W-1:0]   arg;
   } start_type;

endpackage

`default_nettype wire

// ===== hdl/ccce_cfg_regs.sv =====
// ============================================================================
// ccce_cfg_regs
// Decodes register writes, holds the per-channel arguments and issues
// channel start commands on mode writes.
// ============================================================================
`default_nettype none

module ccce_cfg_regs #(
   parameter int CHANNELS = ccce_pkg::CHANNELS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_we,
   input  wire logic [ccce_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  wire logic [ccce_pkg::CSR_DATA_W-1:0]           csr_wdata,
   output logic [CHANNELS-1:0][ccce_pkg::ARG_W-1:0]       reg_arg,
   output ccce_pkg::start_type                            start
);

   logic [CHANNELS-1:0][ccce_pkg::ARG_W-1:0] arg_ff;
   logic [CHANNELS-1:0][ccce_pkg::ARG_W-1:0] arg_in;
   logic                                     mode_wr;
   logic                                     arg_wr;
   logic [ccce_pkg::CHAN_W-1:0]              wr_chan;

   assign mode_wr = csr_we && (csr_index < ccce_pkg::CSR_ARG_BASE);
   assign arg_wr  = csr_we && (csr_index >= ccce_pkg::CSR_ARG_BASE)
                    && (csr_index < ccce_pkg::CSR_REG_END);
   assign wr_chan = csr_index[ccce_pkg::CHAN_W-1:0];

   always_comb begin
      arg_in      = arg_ff;
      start.valid   = 1'b0;
      start.channel = wr_chan;
      start.mode    = csr_wdata[ccce_pkg::MODE_W-1:0];
      start.arg     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (wr_chan == ccce_pkg::CHAN_W'(i)) begin
            start.valid = mode_wr;
            start.arg   = arg_ff[i];
            if (arg_wr) begin
               arg_in[i] = csr_wdata[ccce_pkg::ARG_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_ff <= '0;
      end else begin
         arg_ff <= arg_in;
      end
   end

   assign reg_arg = arg_ff;

endmodule

`default_nettype wire

// ===== hdl/ccce_chan_core.sv =====
// ============================================================================
// ccce_chan_core
// Per-channel state and the single-pass evaluation of one request.
// ============================================================================
`default_nettype none

module ccce_chan_core #(
   parameter int CHANNELS = ccce_pkg::CHANNELS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      fire,
   input  wire ccce_pkg::item_type                        item,
   input  wire ccce_pkg::start_type                       start,
   input  wire logic [CHANNELS-1:0][ccce_pkg::ARG_W-1:0]  reg_arg,
   output ccce_pkg::result_type                           result
);

   logic [CHANNELS-1:0][ccce_pkg::MODE_W-1:0]  live_mode_ff, live_mode_in;
   logic [CHANNELS-1:0][ccce_pkg::OVF_W-1:0]   ovf_cnt_ff, ovf_cnt_in;
   logic [CHANNELS-1:0][ccce_pkg::STAMP_W-1:0] last_stamp_ff, last_stamp_in;
   logic [CHANNELS-1:0][ccce_pkg::VAL_W-1:0]   next_cmp_ff, next_cmp_in;

   logic                           hit;
   logic [ccce_pkg::MODE_W-1:0]    sel_mode;
   logic [ccce_pkg::OVF_W-1:0]     sel_ovf;
   logic [ccce_pkg::STAMP_W-1:0]   sel_last;
   logic [ccce_pkg::VAL_W-1:0]     sel_cmp;
   logic [ccce_pkg::ARG_W-1:0]     sel_arg;
   logic [ccce_pkg::STAMP_W-1:0]   stamp;
   logic [ccce_pkg::DIFF_W-1:0]    diff;
   logic [ccce_pkg::DIFF_W-1:0]    width_w;
   logic [ccce_pkg::VAL_W-1:0]     dur;
   logic [ccce_pkg::VAL_W-1:0]     cmp_sum;
   logic                           is_cap;
   logic                           is_once;
   logic                           is_pwm;
   logic                           is_timer;
   logic                           is_pulse;

   always_comb begin
      hit      = 1'b0;
      sel_mode = '0;
      sel_ovf  = '0;
      sel_last = '0;
      sel_cmp  = '0;
      sel_arg  = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (item.event_channel == ccce_pkg::CHAN_W'(i)) begin
            hit      = item.event_valid;
            sel_mode = live_mode_ff[i];
            sel_ovf  = ovf_cnt_ff[i] + ccce_pkg::OVF_W'(item.overflow);
            sel_last = last_stamp_ff[i];
            sel_cmp  = next_cmp_ff[i];
            sel_arg  = reg_arg[i];
         end
      end
   end

   always_comb begin
      is_cap   = 1'b0;
      is_once  = 1'b0;
      is_pwm   = 1'b0;
      is_timer = 1'b0;
      is_pulse = 1'b0;
      unique case (ccce_pkg::mode_type'(sel_mode))
         ccce_pkg::MODE_CAP_CONT: begin
            is_cap = hit;
         end
         ccce_pkg::MODE_CAP_ONCE: begin
            is_cap  = hit;
            is_once = hit;
         end
         ccce_pkg::MODE_PWM: begin
            is_pwm = hit;
         end
         ccce_pkg::MODE_TIMER: begin
            is_timer = hit;
         end
         ccce_pkg::MODE_PULSE: begin
            is_pulse = hit;
         end
         default: begin
            is_cap = 1'b0;
         end
      endcase
   end

   // The stamp uses the overflow count after this request's own overflow.
   assign stamp   = {sel_ovf, item.capture_value};
   assign diff    = ccce_pkg::DIFF_W'(stamp) - ccce_pkg::DIFF_W'(sel_last);
   assign width_w = diff >> sel_arg[ccce_pkg::SHIFT_W-1:0];
   assign dur     = (width_w[23:16] != 8'd0) ? ccce_pkg::DUR_SAT : width_w[15:0];
   assign cmp_sum = sel_cmp + sel_arg;

   always_comb begin
      result.report_valid   = is_cap || is_pwm || is_timer;
      result.report_channel = item.event_valid ? item.event_channel : '0;
      result.duration       = is_cap ? dur : '0;
      result.compare_valid  = is_timer || is_pulse;
      result.compare_value  = (is_timer || is_pulse) ? cmp_sum : '0;
      result.disarm         = is_once;
   end

   always_comb begin
      live_mode_in  = live_mode_ff;
      ovf_cnt_in    = ovf_cnt_ff;
      last_stamp_in = last_stamp_ff;
      next_cmp_in   = next_cmp_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         if (fire && item.overflow) begin
            ovf_cnt_in[i] = ovf_cnt_ff[i] + 8'd1;
         end
         if (fire && (item.event_channel == ccce_pkg::CHAN_W'(i))) begin
            if (is_cap) begin
               last_stamp_in[i] = stamp;
            end
            if (is_once) begin
               live_mode_in[i] = ccce_pkg::MODE_OFF;
            end
            if (is_timer || is_pulse) begin
               next_cmp_in[i] = cmp_sum;
            end
         end
         if (start.valid && (start.channel == ccce_pkg::CHAN_W'(i))) begin
            live_mode_in[i] = start.mode;
            if ((start.mode == ccce_pkg::MODE_CAP_CONT)
                || (start.mode == ccce_pkg::MODE_CAP_ONCE)) begin
               ovf_cnt_in[i]    = '0;
               last_stamp_in[i] = '0;
            end else if ((start.mode == ccce_pkg::MODE_TIMER)
                         || (start.mode == ccce_pkg::MODE_PULSE)) begin
               next_cmp_in[i] = start.arg;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_mode_ff  <= '0;
         ovf_cnt_ff    <= '0;
         last_stamp_ff <= '0;
         next_cmp_ff   <= '0;
      end else begin
         live_mode_ff  <= live_mode_in;
         ovf_cnt_ff    <= ovf_cnt_in;
         last_stamp_ff <= last_stamp_in;
         next_cmp_ff   <= next_cmp_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/capture_compare_channel_engine_core.sv =====
// ============================================================================
// capture_compare_channel_engine_core
// Capture/compare engine for up to four channels sharing one counter.
// ============================================================================
// Usage: each request on the req_ channel carries an optional counter
// overflow and an optional channel event with a captured count. Every
// request yields exactly one response on the rsp_ channel, in order.
// Capture channels report the shifted, saturated pulse width; timer and
// pulse channels return their next compare value; pwm and timer report
// a tick with zero duration.
// Registers are written through the csr_ port, one per cycle; the user must
// write them only while no request is in flight, which the block does not
// enforce. Writing a mode register (re)starts the channel. A request passes
// through one input register and one response register, with the channel
// state between them. Throughput is one request per cycle while rsp_tready is
// high. The input side stays ready while a finished response waits, as long as
// the response register can drain; when the receiver stalls, one request is
// held in the input register and req_tready falls after that. Reset clears
// the valid flags, arguments and channel state, so every channel starts unused.
// ============================================================================
`default_nettype none

module capture_compare_channel_engine_core #(
   parameter int CHANNELS = ccce_pkg::CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // overflow [0], capture_value [16:1], zero fill [23:17]
   input  wire logic [ccce_pkg::REQ_DATA_W-1:0]     req_tdata,
   // event_valid [0], event_channel [2:1]
   input  wire logic [ccce_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // duration [15:0], compare_value [31:16]
   output logic [ccce_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // report_valid [0], report_channel [2:1], compare_valid [3], disarm [4]
   output logic [ccce_pkg::RSP_USER_W-1:0]          rsp_tuser,
   input  wire logic                                csr_we,
   input  wire logic [ccce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ccce_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic                                      in_vld_ff, in_vld_in;
   ccce_pkg::item_type                        in_ff, in_in;
   logic                                      out_vld_ff, out_vld_in;
   ccce_pkg::result_type                      out_ff, out_in;
   logic                                      advance;
   logic                                      accept;
   logic [CHANNELS-1:0][ccce_pkg::ARG_W-1:0]  reg_arg;
   ccce_pkg::start_type                       start;
   ccce_pkg::result_type                      result;

   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      in_in               = in_ff;
      if (accept) begin
         in_in.overflow      = req_tdata[0];
         in_in.capture_value = req_tdata[16:1];
         in_in.event_valid   = req_tuser[0];
         in_in.event_channel = req_tuser[2:1];
      end
      in_vld_in  = accept || (in_vld_ff && !advance);
      out_in     = advance ? result : out_ff;
      out_vld_in = advance || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   ccce_cfg_regs #(
      .CHANNELS (CHANNELS)
   ) u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .reg_arg   (reg_arg),
      .start     (start)
   );

   ccce_chan_core #(
      .CHANNELS (CHANNELS)
   ) u_chan_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_ff),
      .start   (start),
      .reg_arg (reg_arg),
      .result  (result)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.compare_value, out_ff.duration};
   assign rsp_tuser  = {out_ff.disarm, out_ff.compare_valid, out_ff.report_channel,
                        out_ff.report_valid};

endmodule

`default_nettype wire
